FILE: hw/rtl/pkcs1_v15_block_unpad_top_macros.svh
// Assertion macros for the PKCS#1 v1.5 unpad block.
// Used by pkcs1_v15_block_unpad_top; needs i_clk and i_rst_n in scope.
`ifndef PKCS1_V15_BLOCK_UNPAD_TOP_MACROS_SVH
`define PKCS1_V15_BLOCK_UNPAD_TOP_MACROS_SVH

// antecedent implies consequent in the same cycle
`define PKUV_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// antecedent implies consequent in the next cycle
`define PKUV_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/pkuv_pkg.sv
// Shared types and constants for the PKCS#1 v1.5 unpad block.
// No dependencies.
package pkuv_pkg;

    localparam int BYTE_W    = 8;
    localparam int BB_W      = 10;  // block_bytes register width
    localparam int LEN_W     = 11;  // effective length and position compares
    localparam int MLEN_W    = 10;
    localparam int STATUS_W  = 2;
    localparam int CFG_IDX_W = 1;
    localparam int Q_DEPTH   = 2;
    localparam int Q_PTR_W   = 1;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PAD_TYPE    = 1'b1;

    localparam logic [BYTE_W-1:0] BYTE_ZERO  = 8'h00;
    localparam logic [BYTE_W-1:0] BYTE_TYPE1 = 8'h01;
    localparam logic [BYTE_W-1:0] BYTE_TYPE2 = 8'h02;
    localparam logic [BYTE_W-1:0] BYTE_FF    = 8'hFF;

    localparam logic [LEN_W-1:0] MIN_BLOCK = 11'd11;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BAD   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_SHORT = 2'd2;

    typedef enum logic [2:0] {
        PH_ZERO,
        PH_TYPE,
        PH_PAD,
        PH_MSG,
        PH_ERR
    } t_phase;

    typedef struct packed {
        logic [BB_W-1:0] block_bytes;
        logic            pad_type;
    } t_cfg;

    typedef struct packed {
        logic [BYTE_W-1:0]   msg_byte;
        logic                byte_valid;
        logic                block_end;
        logic [STATUS_W-1:0] status;
        logic [MLEN_W-1:0]   msg_len;
    } t_res;

endpackage

FILE: hw/rtl/pkuv_front.sv
// Front end: header/padding parser, one byte per cycle unless the queue is full, emits result words.
// Depends on pkuv_pkg.
module pkuv_front #(
    parameter int MAX_BLOCK_BYTES = 512
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  pkuv_pkg::t_cfg                i_cfg,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [pkuv_pkg::BYTE_W-1:0]   i_pad_byte,
    input  logic                          i_q_full,
    output logic                          o_push,
    output pkuv_pkg::t_res                o_res
);
    import pkuv_pkg::*;

    localparam int PW = $clog2(MAX_BLOCK_BYTES);
    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_BLOCK_BYTES);

    t_phase            r_phase, n_phase;
    logic [PW-1:0]     r_pos;
    logic [MLEN_W-1:0] r_count, n_count;
    logic              r_pad_seen, n_pad_seen;

    logic [LEN_W-1:0]  len_raw, len;
    logic              accept, is_last, short_blk, valid;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    // zero acts as one, above the max clamps to the max
    assign len_raw   = (i_cfg.block_bytes == '0) ? LEN_W'(1)
                                                 : LEN_W'(i_cfg.block_bytes);
    assign len       = (len_raw > MAX_LEN) ? MAX_LEN : len_raw;
    assign is_last   = (LEN_W'(r_pos) + LEN_W'(1)) >= len;
    assign short_blk = len < MIN_BLOCK;

    always_comb begin
        n_phase    = r_phase;
        n_count    = r_count;
        n_pad_seen = r_pad_seen;
        valid      = 1'b0;
        if (!short_blk) begin
            case (r_phase)
                PH_ZERO: begin
                    n_phase = (i_pad_byte == BYTE_ZERO) ? PH_TYPE : PH_ERR;
                end
                PH_TYPE: begin
                    n_phase = (i_pad_byte == (i_cfg.pad_type ? BYTE_TYPE2 : BYTE_TYPE1))
                            ? PH_PAD : PH_ERR;
                end
                PH_PAD: begin
                    if (i_cfg.pad_type) begin
                        if (i_pad_byte == BYTE_ZERO) n_phase = PH_MSG;
                    end else if (i_pad_byte == BYTE_FF) begin
                        n_pad_seen = 1'b1;
                    end else if (i_pad_byte == BYTE_ZERO && r_pad_seen) begin
                        n_phase = PH_MSG;
                    end else begin
                        n_phase = PH_ERR;
                    end
                end
                PH_MSG: begin
                    valid   = 1'b1;
                    n_count = r_count + MLEN_W'(1);
                end
                default: begin
                    n_phase = PH_ERR;
                end
            endcase
        end

        o_res.msg_byte   = valid ? i_pad_byte : '0;
        o_res.byte_valid = valid;
        o_res.block_end  = is_last;
        o_res.status     = ST_OK;
        o_res.msg_len    = '0;
        if (is_last) begin
            if (short_blk) begin
                o_res.status = ST_SHORT;
            end else if (n_phase == PH_MSG) begin
                o_res.msg_len = n_count;
            end else begin
                o_res.status = ST_BAD;
            end
        end
    end

    assign o_push = accept && (valid || is_last);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_ZERO;
            r_pos      <= '0;
            r_count    <= '0;
            r_pad_seen <= 1'b0;
        end else if (accept) begin
            if (is_last) begin
                r_phase    <= PH_ZERO;
                r_pos      <= '0;
                r_count    <= '0;
                r_pad_seen <= 1'b0;
            end else begin
                // not last means pos+1 < len <= max, so no overflow
                r_phase    <= n_phase;
                r_pos      <= r_pos + PW'(1);
                r_count    <= n_count;
                r_pad_seen <= n_pad_seen;
            end
        end
    end

endmodule

FILE: hw/rtl/pkuv_queue.sv
// Back end: two-entry result queue whose head drives the output channel.
// Depends on pkuv_pkg.
module pkuv_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  pkuv_pkg::t_res i_res,
    output logic           o_full,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    output pkuv_pkg::t_res o_res
);
    import pkuv_pkg::*;

    localparam int CNT_W = $clog2(Q_DEPTH + 1);

    t_res               r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0] r_wptr, r_rptr;
    logic [CNT_W-1:0]   r_count;
    logic               pop;

    assign o_full      = (r_count == CNT_W'(Q_DEPTH));
    assign o_out_valid = (r_count != '0);
    assign o_res       = r_mem[r_rptr];
    assign pop         = o_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wptr] <= i_res;
    end

    // depth is a power of two, pointers wrap on their own
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) r_wptr <= r_wptr + Q_PTR_W'(1);
            if (pop)    r_rptr <= r_rptr + Q_PTR_W'(1);
            case ({i_push, pop})
                2'b10:   r_count <= r_count + CNT_W'(1);
                2'b01:   r_count <= r_count - CNT_W'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

FILE: hw/rtl/pkcs1_v15_block_unpad_top.sv
// PKCS#1 v1.5 block unpad, top level: config registers, parser, result queue.
// Depends on pkuv_pkg, pkuv_front, pkuv_queue and the macros header.
//
// Takes one byte of a decrypted block per cycle, checks the 00 01 / 00 02
// header and the padding up to the 00 separator, and returns one word per
// message byte; the block's final byte always gives a word with status and
// length. Sustained rate is one byte per clock: the parser decides each byte
// combinationally and a two-entry queue decouples it from the output, so
// input stalls only once two result words are waiting. An accepted byte's
// result word is registered into the queue. Padding bytes make no word.
// Registers must be written only while idle; the block does not enforce this.
// block_bytes 0 acts as 1 and values above MAX_BLOCK_BYTES clamp to it.
`include "pkcs1_v15_block_unpad_top_macros.svh"

module pkcs1_v15_block_unpad_top #(
    parameter int MAX_BLOCK_BYTES = 512
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [pkuv_pkg::CFG_IDX_W-1:0]   i_cfg_idx,
    input  logic [pkuv_pkg::BB_W-1:0]        i_cfg_wdata,
    input  logic                             i_in_valid,
    output logic                             o_in_ready,
    input  logic [pkuv_pkg::BYTE_W-1:0]      i_pad_byte,
    output logic                             o_out_valid,
    input  logic                             i_out_ready,
    output logic [pkuv_pkg::BYTE_W-1:0]      o_msg_byte,
    output logic                             o_byte_valid,
    output logic                             o_block_end,
    output logic [pkuv_pkg::STATUS_W-1:0]    o_status,
    output logic [pkuv_pkg::MLEN_W-1:0]      o_msg_len
);
    import pkuv_pkg::*;

    t_cfg  r_cfg;
    t_res  push_res, head_res;
    logic  push, q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.block_bytes <= BB_W'(128);
            r_cfg.pad_type    <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BLOCK_BYTES: r_cfg.block_bytes <= i_cfg_wdata;
                CFG_PAD_TYPE:    r_cfg.pad_type    <= i_cfg_wdata[0];
                default:         r_cfg             <= r_cfg;
            endcase
        end
    end

    pkuv_front #(
        .MAX_BLOCK_BYTES(MAX_BLOCK_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_pad_byte (i_pad_byte),
        .i_q_full   (q_full),
        .o_push     (push),
        .o_res      (push_res)
    );

    pkuv_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_res       (push_res),
        .o_full      (q_full),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_res       (head_res)
    );

    assign o_msg_byte   = head_res.msg_byte;
    assign o_byte_valid = head_res.byte_valid;
    assign o_block_end  = head_res.block_end;
    assign o_status     = head_res.status;
    assign o_msg_len    = head_res.msg_len;

    `PKUV_ASSERT_SAME(a_word_has_content, o_out_valid, o_byte_valid || o_block_end, "empty result word")
    `PKUV_ASSERT_SAME(a_mid_block_clean, o_out_valid && !o_block_end, o_status == ST_OK && o_msg_len == '0, "status or length set before block end")
    `PKUV_ASSERT_SAME(a_err_no_len, o_out_valid && o_status != ST_OK, o_msg_len == '0 && !o_byte_valid, "error word carries data")
    `PKUV_ASSERT_NEXT(a_full_stalls, push && q_full, 1'b0, "push into full queue")

endmodule

FILE: verif/pkcs1_v15_block_unpad_top_tb.sv
// Self-checking testbench for pkcs1_v15_block_unpad_top: PKCS#1 v1.5 header and padding
// checks, message byte extraction, block end status and length. Depends on pkuv_pkg and the RTL.
`timescale 1ns / 1ps

module pkcs1_v15_block_unpad_top_tb;

    import pkuv_pkg::*;

    localparam int MAX_BYTES     = 512;
    localparam int ITEMS         = 1500;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_HOLD     = 300;

    typedef enum logic [1:0] {JOB_BYTE, JOB_CFG, JOB_DRAIN, JOB_HOLD} t_job_kind;
    typedef enum logic [1:0] {SHAPE_GOOD, SHAPE_BROKEN, SHAPE_NOISE} t_blk_shape;

    typedef struct {
        t_job_kind              kind;
        logic [CFG_IDX_W-1:0]   idx;
        logic [BB_W-1:0]        val;
    } t_feed_job;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [CFG_IDX_W-1:0]   i_cfg_idx;
    logic [BB_W-1:0]        i_cfg_wdata;
    logic                   i_in_valid;
    logic                   o_in_ready;
    logic [BYTE_W-1:0]      i_pad_byte;
    logic                   o_out_valid;
    logic                   i_out_ready;
    logic [BYTE_W-1:0]      o_msg_byte;
    logic                   o_byte_valid;
    logic                   o_block_end;
    logic [STATUS_W-1:0]    o_status;
    logic [MLEN_W-1:0]      o_msg_len;

    // stimulus and expected words
    t_feed_job  byte_feed[$];
    t_res       expected_words[$];

    // predictor copy of the registers and parse state
    logic [BB_W-1:0]    cfg_len;
    logic               cfg_type;
    logic [LEN_W-1:0]   blk_pos;
    t_phase             parse_ph;
    logic [MLEN_W-1:0]  msg_cnt;
    logic               ff_seen;

    int unsigned bytes_offered, bytes_taken;
    int unsigned tx_gap, tx_calm, rx_gap, rx_calm;
    int unsigned settle, hold_left, hold_reqs, holds_done;
    int unsigned misses, words_checked, msg_words;
    int unsigned blocks_ok, blocks_bad, blocks_short;

    pkcs1_v15_block_unpad_top #(
        .MAX_BLOCK_BYTES(MAX_BYTES)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg_we(i_cfg_we),
        .i_cfg_idx(i_cfg_idx),
        .i_cfg_wdata(i_cfg_wdata),
        .i_in_valid(i_in_valid),
        .o_in_ready(o_in_ready),
        .i_pad_byte(i_pad_byte),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_msg_byte(o_msg_byte),
        .o_byte_valid(o_byte_valid),
        .o_block_end(o_block_end),
        .o_status(o_status),
        .o_msg_len(o_msg_len)
    );

    initial begin
        i_clk       = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_idx   = CFG_BLOCK_BYTES;
        i_cfg_wdata = '0;
        i_in_valid  = 1'b0;
        i_pad_byte  = '0;
        i_out_ready = 1'b0;
    end

    always #10 i_clk = ~i_clk;

    initial begin
        #20_000_000;
        $display("pkcs1_v15_block_unpad_top test failed");
        $finish;
    end

    // ---------------------------------------------------------------- predictor

    task automatic restart_block();
        blk_pos  = '0;
        parse_ph = PH_ZERO;
        msg_cnt  = '0;
        ff_seen  = 1'b0;
    endtask

    task automatic unpad_byte(input logic [BYTE_W-1:0] b);
        int     eff;
        logic   last, short_blk, carry;
        t_res   w;
        eff = (cfg_len == 0) ? 1 : ((cfg_len > MAX_BYTES) ? MAX_BYTES : int'(cfg_len));
        last      = (int'(blk_pos) + 1) >= eff;
        short_blk = eff < int'(MIN_BLOCK);
        carry     = 1'b0;
        if (!short_blk) begin
            case (parse_ph)
                PH_ZERO: begin
                    if (b == BYTE_ZERO) parse_ph = PH_TYPE;
                    else parse_ph = PH_ERR;
                end
                PH_TYPE: begin
                    if (b == (cfg_type ? BYTE_TYPE2 : BYTE_TYPE1)) parse_ph = PH_PAD;
                    else parse_ph = PH_ERR;
                end
                PH_PAD: begin
                    if (cfg_type) begin
                        if (b == BYTE_ZERO) parse_ph = PH_MSG;
                    end else if (b == BYTE_FF) begin
                        ff_seen = 1'b1;
                    end else if (b == BYTE_ZERO && ff_seen) begin
                        parse_ph = PH_MSG;
                    end else begin
                        parse_ph = PH_ERR;
                    end
                end
                PH_MSG: begin
                    carry   = 1'b1;
                    msg_cnt = msg_cnt + 1'b1;
                end
                default: parse_ph = PH_ERR;
            endcase
        end
        if (!carry && !last) begin
            blk_pos = blk_pos + 1'b1;
        end else begin
            w            = '0;
            w.msg_byte   = carry ? b : '0;
            w.byte_valid = carry;
            w.block_end  = last;
            if (carry) msg_words++;
            if (last) begin
                if (short_blk) begin
                    w.status = ST_SHORT;
                    blocks_short++;
                end else if (parse_ph == PH_MSG) begin
                    w.status  = ST_OK;
                    w.msg_len = msg_cnt;
                    blocks_ok++;
                end else begin
                    w.status = ST_BAD;
                    blocks_bad++;
                end
                restart_block();
            end else begin
                blk_pos = blk_pos + 1'b1;
            end
            expected_words.push_back(w);
        end
    endtask

    task automatic log_miss(input string why, input t_res want, input t_res got);
        misses++;
        if (misses <= 10)
            $display("MISMATCH (%s) at %0t: want byte=%02h v=%0d end=%0d st=%0d len=%0d",
                     why, $realtime, want.msg_byte, want.byte_valid, want.block_end,
                     want.status, want.msg_len,
                     "  got byte=%02h v=%0d end=%0d st=%0d len=%0d",
                     got.msg_byte, got.byte_valid, got.block_end, got.status, got.msg_len);
    endtask

    // predictor update on accepted input, compare on accepted output word
    always @(posedge i_clk) begin
        t_res want;
        t_res got;
        if (!i_rst_n) begin
            cfg_len  = 10'd128;
            cfg_type = 1'b1;
            restart_block();
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx == CFG_BLOCK_BYTES) cfg_len = i_cfg_wdata;
                else cfg_type = i_cfg_wdata[0];
            end
            if (i_in_valid && o_in_ready) begin
                bytes_taken++;
                unpad_byte(i_pad_byte);
            end
            if (o_out_valid && i_out_ready) begin
                got.msg_byte   = o_msg_byte;
                got.byte_valid = o_byte_valid;
                got.block_end  = o_block_end;
                got.status     = o_status;
                got.msg_len    = o_msg_len;
                if (expected_words.size() == 0) begin
                    log_miss("unexpected word", '0, got);
                end else begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (got.msg_byte !== want.msg_byte || got.byte_valid !== want.byte_valid ||
                        got.block_end !== want.block_end || got.status !== want.status ||
                        got.msg_len !== want.msg_len)
                        log_miss("field", want, got);
                end
            end
        end
    end

    // ---------------------------------------------------------------- idling

    function automatic int unsigned next_gap(inout int unsigned calm);
        int unsigned roll;
        if (calm != 0) begin
            calm--;
            return 0;
        end
        roll = $urandom_range(0, 199);
        if (roll == 0) begin
            calm = $urandom_range(50, 200);   // stretch with no idling
            return 0;
        end
        if (roll < 120) return 0;
        if (roll < 180) return $urandom_range(1, 3);
        if (roll < 196) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // sender: one byte per handshake, config writes only once drained
    always @(negedge i_clk) begin
        t_feed_job  job;
        logic       nxt_valid;
        logic       nxt_we;
        if (i_rst_n) begin
            nxt_valid = 1'b0;
            nxt_we    = 1'b0;
            if (bytes_taken != bytes_offered) begin
                nxt_valid = 1'b1;
            end else if (tx_gap != 0) begin
                tx_gap--;
            end else if (byte_feed.size() != 0) begin
                job = byte_feed[0];
                case (job.kind)
                    JOB_BYTE: begin
                        i_pad_byte <= job.val[BYTE_W-1:0];
                        nxt_valid = 1'b1;
                        bytes_offered++;
                        void'(byte_feed.pop_front());
                        tx_gap = next_gap(tx_calm);
                    end
                    JOB_HOLD: begin
                        hold_reqs <= hold_reqs + 1;
                        void'(byte_feed.pop_front());
                    end
                    default: begin
                        // padding bytes make no word, so let the parser settle too
                        if (expected_words.size() != 0) begin
                            settle = 0;
                        end else if (settle < SETTLE_CYCLES) begin
                            settle++;
                        end else begin
                            settle = 0;
                            if (job.kind == JOB_CFG) begin
                                nxt_we = 1'b1;
                                i_cfg_idx   <= job.idx;
                                i_cfg_wdata <= job.val;
                            end
                            void'(byte_feed.pop_front());
                        end
                    end
                endcase
            end
            i_in_valid <= nxt_valid;
            i_cfg_we   <= nxt_we;
        end
    end

    // receiver: random stalls, plus a long hold on request
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (hold_left != 0) begin
                hold_left--;
                if (hold_left == 0) holds_done++;
                i_out_ready <= 1'b0;
            end else if (holds_done != hold_reqs) begin
                hold_left = LONG_HOLD;
                i_out_ready <= 1'b0;
            end else if (rx_gap != 0) begin
                rx_gap--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                rx_gap = next_gap(rx_calm);
            end
        end
    end

    // ---------------------------------------------------------------- stimulus

    task automatic push_byte(input logic [BYTE_W-1:0] b);
        t_feed_job job;
        job.kind = JOB_BYTE;
        job.idx  = CFG_BLOCK_BYTES;
        job.val  = '0;
        job.val[BYTE_W-1:0] = b;
        byte_feed.push_back(job);
    endtask

    task automatic push_job(input t_job_kind kind, input logic [CFG_IDX_W-1:0] idx,
                            input logic [BB_W-1:0] val);
        t_feed_job job;
        job.kind = kind;
        job.idx  = idx;
        job.val  = val;
        byte_feed.push_back(job);
    endtask

    task automatic push_seq(input logic [BYTE_W-1:0] s[$]);
        foreach (s[i]) push_byte(s[i]);
    endtask

    // one block of len bytes: well-formed, broken in one way, or random
    task automatic queue_block(input int len, input logic ptype, input t_blk_shape shape);
        logic [BYTE_W-1:0] blk[$];
        logic [BYTE_W-1:0] marker;
        int sep, hi, at, i;
        marker = ptype ? BYTE_TYPE2 : BYTE_TYPE1;
        if (len < int'(MIN_BLOCK) || shape == SHAPE_NOISE) begin
            for (i = 0; i < len; i++) blk.push_back($urandom_range(0, 255));
            if (len >= 2 && $urandom_range(0, 1)) begin
                blk[0] = BYTE_ZERO;
                blk[1] = marker;
            end
        end else begin
            hi = (len > 24) ? 2 + len / 2 : len - 1;
            if ($urandom_range(0, 19) == 0) sep = len;            // no separator
            else if ($urandom_range(0, 9) == 0) sep = len - 1;    // separator on final byte
            else sep = $urandom_range(ptype ? 2 : 3, hi);
            for (i = 0; i < len; i++) begin
                if (i == 0) blk.push_back(BYTE_ZERO);
                else if (i == 1) blk.push_back(marker);
                else if (i < sep) blk.push_back(ptype ? $urandom_range(1, 255) : BYTE_FF);
                else if (i == sep) blk.push_back(BYTE_ZERO);
                else blk.push_back($urandom_range(0, 255));
            end
            if (shape == SHAPE_BROKEN) begin
                case ($urandom_range(0, 3))
                    0: blk[0] = $urandom_range(1, 255);
                    1: blk[1] = marker ^ BYTE_W'($urandom_range(1, 255));
                    2: begin
                        if (!ptype) begin
                            blk[2] = BYTE_ZERO;                   // FF run empty
                        end else begin
                            for (i = 2; i < len; i++) blk[i] = $urandom_range(1, 255);
                        end
                    end
                    default: begin
                        at = $urandom_range(2, (sep > 3) ? sep - 1 : 2);
                        blk[at] = $urandom_range(0, 255);
                    end
                endcase
            end
        end
        push_seq(blk);
    endtask

    initial begin
        logic [BYTE_W-1:0]  seq[$];
        logic [BB_W-1:0]    reg_len;
        logic               ptype;
        t_blk_shape         shape;
        int                 eff, phase, nblk, roll, k, fed_bytes;

        bytes_offered = 0;
        bytes_taken   = 0;
        tx_gap = 0; tx_calm = 0; rx_gap = 0; rx_calm = 0;
        settle = 0; hold_left = 0; hold_reqs = 0; holds_done = 0;
        misses = 0; words_checked = 0; msg_words = 0;
        blocks_ok = 0; blocks_bad = 0; blocks_short = 0;

        // type 1, shortest legal length, message bytes at the extremes
        push_job(JOB_CFG, CFG_BLOCK_BYTES, 10'd11);
        push_job(JOB_CFG, CFG_PAD_TYPE, 10'd0);
        seq = '{8'h00, 8'h01, 8'hFF, 8'h00, 8'h00, 8'hFF, 8'h80, 8'h7F, 8'h01, 8'hFE, 8'h55};
        push_seq(seq);
        // type 2, separator lands on the final byte
        push_job(JOB_CFG, CFG_PAD_TYPE, 10'd1);
        seq = '{8'h00, 8'h02, 8'hFF, 8'h01, 8'h80, 8'h7F, 8'h55, 8'hAA, 8'h33, 8'hCC, 8'h00};
        push_seq(seq);
        // length 0 behaves as a one-byte short block
        push_job(JOB_CFG, CFG_BLOCK_BYTES, 10'd0);
        push_byte(8'hAB);
        // bad marker, then length cut below the position mid-block
        push_job(JOB_CFG, CFG_BLOCK_BYTES, 10'd11);
        seq = '{8'h00, 8'h01};
        push_seq(seq);
        push_job(JOB_CFG, CFG_PAD_TYPE, 10'd0);
        push_job(JOB_CFG, CFG_BLOCK_BYTES, 10'd1);
        push_byte(8'h00);

        // random phases: clamp extremes first, then a long receiver hold
        phase = 0;
        fed_bytes = 0;
        while (fed_bytes < ITEMS) begin
            if (phase == 0) begin
                reg_len = 10'd1023;
                ptype   = 1'b0;
            end else if (phase == 1) begin
                reg_len = MAX_BYTES;
                ptype   = 1'b1;
            end else if (phase == 2) begin
                reg_len = 10'd40;
                ptype   = $urandom_range(0, 1);
            end else begin
                roll = $urandom_range(0, 99);
                if (roll < 10) reg_len = $urandom_range(0, 10);
                else if (roll < 88) reg_len = $urandom_range(11, 48);
                else if (roll < 98) reg_len = $urandom_range(49, 128);
                else reg_len = $urandom_range(129, 1023);
                ptype = $urandom_range(0, 1);
            end
            eff = (reg_len == 0) ? 1 : ((reg_len > MAX_BYTES) ? MAX_BYTES : int'(reg_len));
            push_job(JOB_CFG, CFG_BLOCK_BYTES, reg_len);
            push_job(JOB_CFG, CFG_PAD_TYPE, BB_W'(ptype));
            if (phase == 2) push_job(JOB_HOLD, CFG_BLOCK_BYTES, '0);
            nblk = (phase < 2) ? 1 : ((phase == 2) ? 4 : $urandom_range(1, 4));
            for (k = 0; k < nblk; k++) begin
                roll = $urandom_range(0, 99);
                if (phase <= 2 || roll < 70) shape = SHAPE_GOOD;
                else if (roll < 88) shape = SHAPE_BROKEN;
                else shape = SHAPE_NOISE;
                queue_block(eff, ptype, shape);
                fed_bytes += eff;
                if ($urandom_range(0, 7) == 0) push_job(JOB_DRAIN, CFG_BLOCK_BYTES, '0);
            end
            phase++;
        end

        i_rst_n = 1'b0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (byte_feed.size() != 0 || bytes_taken != bytes_offered ||
               expected_words.size() != 0)
            @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        misses += expected_words.size();

        $display("Run covered %0d bytes in %0d phases: %0d blocks ok, %0d bad, %0d short.",
                 bytes_taken, phase, blocks_ok, blocks_bad, blocks_short);
        $display("Checked %0d result words, %0d of them message bytes; %0d mismatches.",
                 words_checked, msg_words, misses);
        if (misses == 0)
            $display("pkcs1_v15_block_unpad_top test passed");
        else
            $display("pkcs1_v15_block_unpad_top test failed");
        $finish;
    end

endmodule
